[src/brb_pkg.sv]
// Shared types and constants for the byte ring buffer with commit pointer.
package brb_pkg;

    // Fixed field widths of the item and result beats
    localparam int CMD_W    = 3;
    localparam int COUNT_W  = 11;
    localparam int BYTE_W   = 8;
    localparam int COPIED_W = 7;
    localparam int RDBL_W   = 10;
    localparam int SPACE_W  = 11;
    localparam int CFG_W    = 11;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WR_START = 3'd0,
        CMD_WR_BYTE  = 3'd1,
        CMD_COMMIT   = 3'd2,
        CMD_READ     = 3'd3,
        CMD_PEEK     = 3'd4,
        CMD_STATUS   = 3'd5
    } t_cmd;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_STAT  = 5'b00100,
        S_RADDR = 5'b01000,
        S_RDATA = 5'b10000
    } t_state;

endpackage

[src/brb_ram.sv]
// Generic single-port RAM with registered read data.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/byte_ring_buffer_with_commit_top.sv]
// A non-read command passes the execute and status states; the status state loads
// its result beat, waiting while the result is stalled. A new command is taken only
// when idle. A read or peek uses an address state and a data state per byte on the
// single RAM port; one that copies nothing gives a single status beat.
// Reset (synchronous): pointers and run length cleared, ring size set to DEPTH;
// the byte store is not cleared.
module byte_ring_buffer_with_commit_top #(
    parameter int DEPTH        = 1024,
    parameter int MAX_READ_RUN = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [brb_pkg::CFG_W-1:0]      i_cfg_data,
    // item channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [brb_pkg::CMD_W-1:0]      i_command,
    input  logic [brb_pkg::COUNT_W-1:0]    i_count,
    input  logic [brb_pkg::BYTE_W-1:0]     i_data_in,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [brb_pkg::BYTE_W-1:0]     o_data_out,
    output logic                           o_data_valid,
    output logic                           o_last,
    output logic [brb_pkg::COPIED_W-1:0]   o_copied_count,
    output logic [brb_pkg::RDBL_W-1:0]     o_readable_count,
    output logic [brb_pkg::SPACE_W-1:0]    o_committed_space,
    output logic [brb_pkg::SPACE_W-1:0]    o_write_space,
    output logic                           o_error
);

    import brb_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int SW  = $clog2(DEPTH + 1);
    localparam int SW1 = SW + 1;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [COUNT_W-1:0]  r_count;
    logic [BYTE_W-1:0]   r_data;
    logic [SW-1:0]       r_size;
    logic [PW-1:0]       r_rp;
    logic [PW-1:0]       r_cp;
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_p;
    logic [COUNT_W-1:0]  r_run;
    logic                r_err;
    logic [COPIED_W-1:0] r_k;
    logic [COPIED_W-1:0] r_i;

    logic                r_ovalid;
    logic [BYTE_W-1:0]   r_o_data;
    logic                r_o_dvalid;
    logic                r_o_last;
    logic [COPIED_W-1:0] r_o_copied;
    logic [RDBL_W-1:0]   r_o_rdbl;
    logic [SPACE_W-1:0]  r_o_cspace;
    logic [SPACE_W-1:0]  r_o_wspace;
    logic                r_o_err;

    logic [SW-1:0]       w_readable;
    logic [SW-1:0]       w_wspace;
    logic [SW-1:0]       w_cspace;
    logic [COPIED_W-1:0] w_want;
    logic [COPIED_W-1:0] w_k;
    logic [SW1-1:0]      w_rp_sum;
    logic [PW-1:0]       w_rp_adv;
    logic [31:0]         w_cfg_ext;
    logic [SW-1:0]       w_cfg_size;
    logic                w_out_free;
    logic                w_ram_we;
    logic [PW-1:0]       w_ram_addr;
    logic [BYTE_W-1:0]   w_ram_rdata;
    logic [COPIED_W-1:0] w_i_next;

    // Step a pointer by one slot around the ring
    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p,
                                                 input logic [SW-1:0] size);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(1);
        return (s >= size) ? '0 : PW'(s);
    endfunction

    // Ring distances from the pointer registers
    always_comb begin
        if (r_rp > r_cp) begin
            w_readable = r_size + SW'(r_cp) - SW'(r_rp);
        end else begin
            w_readable = SW'(r_cp) - SW'(r_rp);
        end
        if (r_rp > r_wp) begin
            w_wspace = SW'(r_rp) - SW'(r_wp);
        end else begin
            w_wspace = r_size - (SW'(r_wp) - SW'(r_rp));
        end
        w_cspace = r_size - w_readable;
    end

    // Bytes to copy and the advanced read pointer
    always_comb begin
        if (r_count < COUNT_W'(MAX_READ_RUN)) begin
            w_want = COPIED_W'(r_count);
        end else begin
            w_want = COPIED_W'(MAX_READ_RUN);
        end
        if (32'(w_readable) < 32'(w_want)) begin
            w_k = COPIED_W'(w_readable);
        end else begin
            w_k = w_want;
        end
        w_rp_sum = SW1'(r_rp) + SW1'(w_k);
        if (w_rp_sum >= SW1'(r_size)) begin
            w_rp_adv = PW'(w_rp_sum - SW1'(r_size));
        end else begin
            w_rp_adv = PW'(w_rp_sum);
        end
    end

    // Clamp the written ring size into its legal range
    always_comb begin
        w_cfg_ext = 32'(i_cfg_data);
        if (w_cfg_ext < 32'd2) begin
            w_cfg_size = SW'(2);
        end else if (w_cfg_ext > 32'(DEPTH)) begin
            w_cfg_size = SW'(DEPTH);
        end else begin
            w_cfg_size = SW'(w_cfg_ext);
        end
    end

    assign w_out_free = !r_ovalid || !i_stall;
    assign w_i_next   = r_i + COPIED_W'(1);
    assign w_ram_we   = (r_state == S_EXEC) && (r_cmd == CMD_WR_BYTE) && (r_run != '0);
    assign w_ram_addr = w_ram_we ? r_wp : r_p;

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (r_data),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer and pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= SW'(DEPTH);
            r_rp    <= '0;
            r_cp    <= '0;
            r_wp    <= '0;
            r_run   <= '0;
            r_err   <= 1'b0;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size <= w_cfg_size;
                r_rp   <= '0;
                r_cp   <= '0;
                r_wp   <= '0;
                r_run  <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_STAT;
                    unique case (r_cmd) inside
                        CMD_WR_START: begin
                            if (32'(w_wspace) <= 32'(r_count)) begin
                                r_err <= 1'b1;
                                r_run <= '0;
                            end else begin
                                r_err <= 1'b0;
                                r_run <= r_count;
                            end
                        end
                        CMD_WR_BYTE: begin
                            if (r_run != '0) begin
                                r_err <= 1'b0;
                                r_wp  <= next_slot(r_wp, r_size);
                                r_run <= r_run - COUNT_W'(1);
                            end else begin
                                r_err <= 1'b1;
                            end
                        end
                        CMD_COMMIT: begin
                            r_err <= 1'b0;
                            r_cp  <= r_wp;
                        end
                        CMD_READ, CMD_PEEK: begin
                            r_err <= 1'b0;
                            r_k   <= w_k;
                            r_i   <= '0;
                            if (r_cmd == CMD_READ) begin
                                r_rp <= w_rp_adv;
                            end
                        end
                        default: begin
                            r_err <= 1'b0;
                        end
                    endcase
                end
                S_STAT: begin
                    if ((r_cmd == CMD_READ || r_cmd == CMD_PEEK) && r_k != '0) begin
                        r_state <= S_RADDR;
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RADDR: begin
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    if (w_out_free) begin
                        r_i <= w_i_next;
                        if (w_i_next == r_k) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RADDR;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the accepted beat and walk the copy pointer
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd   <= t_cmd'(i_command);
            r_count <= i_count;
            r_data  <= i_data_in;
        end
        if (r_state == S_EXEC) begin
            r_p <= r_rp;
        end else if (r_state == S_RDATA && w_out_free) begin
            r_p <= next_slot(r_p, r_size);
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_free && ((r_state == S_RDATA) ||
                     (r_state == S_STAT &&
                      !((r_cmd == CMD_READ || r_cmd == CMD_PEEK) && r_k != '0)))) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_o_rdbl   <= RDBL_W'(w_readable);
            r_o_cspace <= SPACE_W'(w_cspace);
            r_o_wspace <= SPACE_W'(w_wspace);
            if (r_state == S_RDATA) begin
                r_o_data   <= w_ram_rdata;
                r_o_dvalid <= 1'b1;
                r_o_last   <= (w_i_next == r_k);
                r_o_copied <= w_i_next;
                r_o_err    <= 1'b0;
            end else if (r_state == S_STAT) begin
                r_o_data   <= '0;
                r_o_dvalid <= 1'b0;
                r_o_last   <= 1'b1;
                r_o_copied <= '0;
                r_o_err    <= r_err;
            end
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_data_out        = r_o_data;
    assign o_data_valid      = r_o_dvalid;
    assign o_last            = r_o_last;
    assign o_copied_count    = r_o_copied;
    assign o_readable_count  = r_o_rdbl;
    assign o_committed_space = r_o_cspace;
    assign o_write_space     = r_o_wspace;
    assign o_error           = r_o_err;

endmodule

[tb/byte_ring_buffer_with_commit_top_test.sv]
// Self-checking testbench for the byte ring buffer with commit pointer.
`timescale 1ns / 1ps

module byte_ring_buffer_with_commit_top_test;
    import brb_pkg::*;

    localparam int RING_DEPTH    = 1024;
    localparam int MAX_RUN       = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int IDLE_LIMIT    = 3000;

    // Codes outside the command set; the block answers them with a status beat
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [BYTE_W-1:0]   data;
        logic                dv;
        logic                last;
        logic [COPIED_W-1:0] copied;
        logic [RDBL_W-1:0]   readable;
        logic [SPACE_W-1:0]  cspace;
        logic [SPACE_W-1:0]  wspace;
        logic                err;
    } t_brb_beat;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  data;
        bit                 pinned;
        logic [RDBL_W-1:0]  readable;
        logic [SPACE_W-1:0] wspace;
        logic               err;
    } t_brb_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [CMD_W-1:0]    i_command = '0;
    logic [COUNT_W-1:0]  i_count = '0;
    logic [BYTE_W-1:0]   i_data_in = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [BYTE_W-1:0]   o_data_out;
    logic                o_data_valid;
    logic                o_last;
    logic [COPIED_W-1:0] o_copied_count;
    logic [RDBL_W-1:0]   o_readable_count;
    logic [SPACE_W-1:0]  o_committed_space;
    logic [SPACE_W-1:0]  o_write_space;
    logic                o_error;

    // Shadow ring state
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [CFG_W-1:0]  size_reg = 11'd1024;
    int                rd_ptr = 0;
    int                cm_ptr = 0;
    int                wr_ptr = 0;
    int                run_left = 0;

    t_brb_beat pending_beats [$];
    t_brb_row  script [$];
    int        mismatch_count = 0;
    int        beats_checked = 0;
    int        items_sent = 0;
    int        quiet_cycles = 0;
    int        sink_hold = 0;
    int        sink_run = 0;
    bit        idle_on = 1'b1;

    byte_ring_buffer_with_commit_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_count          (i_count),
        .i_data_in        (i_data_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_data_out       (o_data_out),
        .o_data_valid     (o_data_valid),
        .o_last           (o_last),
        .o_copied_count   (o_copied_count),
        .o_readable_count (o_readable_count),
        .o_committed_space(o_committed_space),
        .o_write_space    (o_write_space),
        .o_error          (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ring size in effect, clamped to the legal range
    function automatic int ring_len();
        if (size_reg < 2) return 2;
        if (size_reg > RING_DEPTH) return RING_DEPTH;
        return int'(size_reg);
    endfunction

    function automatic int next_slot(input int p);
        return (p + 1 >= ring_len()) ? p + 1 - ring_len() : p + 1;
    endfunction

    function automatic int readable_bytes();
        if (rd_ptr > cm_ptr) return ring_len() + cm_ptr - rd_ptr;
        return cm_ptr - rd_ptr;
    endfunction

    function automatic int free_slots();
        if (rd_ptr > wr_ptr) return rd_ptr - wr_ptr;
        return ring_len() - (wr_ptr - rd_ptr);
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return 11'($urandom_range(0, 8));
        if (roll < 8) return 11'($urandom_range(0, 70));
        return 11'($urandom_range(0, 2047));
    endfunction

    function automatic void push_beat(input logic [BYTE_W-1:0] d, input logic dv,
                                      input logic last, input int copied, input logic err);
        t_brb_beat b;
        int        r;
        r          = readable_bytes();
        b.data     = d;
        b.dv       = dv;
        b.last     = last;
        b.copied   = 7'(copied);
        b.readable = 10'(r);
        b.cspace   = 11'(ring_len() - r);
        b.wspace   = 11'(free_slots());
        b.err      = err;
        pending_beats.push_back(b);
    endfunction

    // Advance the shadow ring by one command and queue the beats it causes
    function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                          input logic [COUNT_W-1:0] cnt,
                                          input logic [BYTE_W-1:0] dat);
        logic [BYTE_W-1:0] grab [MAX_RUN];
        logic              err;
        int                want;
        int                taken;
        int                p;
        err = 1'b0;
        if (cmd == CMD_READ || cmd == CMD_PEEK) begin
            want  = (cnt < MAX_RUN) ? int'(cnt) : MAX_RUN;
            p     = rd_ptr;
            taken = 0;
            while (taken < want && p != cm_ptr) begin
                grab[taken] = ring_mem[p];
                p = next_slot(p);
                taken++;
            end
            if (cmd == CMD_READ) rd_ptr = p;
            if (taken == 0) push_beat(8'h00, 1'b0, 1'b1, 0, 1'b0);
            for (int i = 0; i < taken; i++)
                push_beat(grab[i], 1'b1, i == taken - 1, i + 1, 1'b0);
        end else begin
            case (cmd)
                CMD_WR_START: begin
                    if (free_slots() <= cnt) begin
                        err      = 1'b1;
                        run_left = 0;
                    end else begin
                        run_left = int'(cnt);
                    end
                end
                CMD_WR_BYTE: begin
                    if (run_left > 0) begin
                        ring_mem[wr_ptr] = dat;
                        wr_ptr = next_slot(wr_ptr);
                        run_left--;
                    end else begin
                        err = 1'b1;
                    end
                end
                CMD_COMMIT: cm_ptr = wr_ptr;
                default: ;
            endcase
            push_beat(8'h00, 1'b0, 1'b1, 0, err);
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 30) $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("beat %0d %s got %0h expected %0h",
                                    beats_checked, name, got, want));
    endtask

    // Offer one beat and hold it until the block takes it
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [COUNT_W-1:0] cnt,
                             input logic [BYTE_W-1:0] dat);
        int gap;
        bit took;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_count   <= cnt;
        i_data_in <= dat;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = (o_stall === 1'b0);
            @(posedge i_clk);
        end
        apply_command(cmd, cnt, dat);
        if (cmd <= CMD_STATUS) items_sent++;
    endtask

    // Drop valid and hold the sender until every expected beat is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_ring_size(input logic [CFG_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = value;
        rd_ptr   = 0;
        cm_ptr   = 0;
        wr_ptr   = 0;
        run_left = 0;
    endtask

    // Mostly a full run (start, bytes, commit, read back), otherwise noise
    task automatic random_chunk();
        int roll;
        int cap;
        int run_len;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            cap = free_slots() - 1;
            if ($urandom_range(0, 9) == 0)
                run_len = $urandom_range(0, (cap < 48) ? cap : 48);
            else
                run_len = $urandom_range(0, (cap < 6) ? cap : 6);
            send_item(CMD_WR_START, 11'(run_len), 8'($urandom_range(0, 255)));
            for (int i = 0; i < run_len; i++) begin
                if ($urandom_range(0, 11) == 0)
                    send_item(CMD_COMMIT, pick_count(), 8'($urandom_range(0, 255)));
                send_item(CMD_WR_BYTE, pick_count(), 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 4) != 0)
                send_item(CMD_COMMIT, pick_count(), 8'($urandom_range(0, 255)));
            send_item($urandom_range(0, 1) ? CMD_READ : CMD_PEEK, pick_count(),
                      8'($urandom_range(0, 255)));
        end else begin
            send_item(3'($urandom_range(0, 7)), pick_count(), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_phase(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) random_chunk();
    endtask

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input int cnt, input int dat,
                                    input bit pinned, input int readable, input int wspace,
                                    input logic err);
        t_brb_row r;
        r.cmd      = cmd;
        r.count    = 11'(cnt);
        r.data     = 8'(dat);
        r.pinned   = pinned;
        r.readable = 10'(readable);
        r.wspace   = 11'(wspace);
        r.err      = err;
        script.push_back(r);
    endfunction

    // Randomize receiver stalls: runs of open cycles broken by stall gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (sink_hold > 0) begin
            i_stall   <= 1'b1;
            sink_hold <= sink_hold - 1;
        end else if (sink_run > 0) begin
            i_stall  <= 1'b0;
            sink_run <= sink_run - 1;
        end else begin
            i_stall   <= 1'b0;
            sink_hold <= gap_len();
            sink_run  <= $urandom_range(0, 6);
        end
    end

    // Compare every accepted result beat with the oldest expectation
    always @(posedge i_clk) begin : beat_check
        t_brb_beat want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_beats.size() == 0) begin
                flag_mismatch($sformatf("beat %0d arrived with nothing expected",
                                        beats_checked));
            end else begin
                want = pending_beats.pop_front();
                check_field("data_out", o_data_out, want.data);
                check_field("data_valid", o_data_valid, want.dv);
                check_field("last", o_last, want.last);
                check_field("copied_count", o_copied_count, want.copied);
                check_field("readable_count", o_readable_count, want.readable);
                check_field("committed_space", o_committed_space, want.cspace);
                check_field("write_space", o_write_space, want.wspace);
                check_field("error", o_error, want.err);
            end
            beats_checked++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && o_stall === 1'b0) ||
            (o_valid === 1'b1 && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        // Directed script; pinned rows carry values read straight off the spec
        add_row(CMD_STATUS,   0,    8'h00, 1, 0, 1024, 1'b0);
        add_row(CMD_READ,     5,    8'h00, 1, 0, 1024, 1'b0);
        add_row(CMD_PEEK,     5,    8'h00, 1, 0, 1024, 1'b0);
        add_row(CMD_WR_BYTE,  0,    8'hFF, 1, 0, 1024, 1'b1);  // byte with no run open
        add_row(CMD_WR_START, 1024, 8'h00, 1, 0, 1024, 1'b1);  // run as long as the space
        add_row(CMD_WR_START, 2047, 8'hFF, 1, 0, 1024, 1'b1);
        add_row(CMD_WR_START, 0,    8'h00, 1, 0, 1024, 1'b0);
        add_row(CMD_WR_START, 4,    8'h00, 0, 0, 0, 1'b0);
        add_row(CMD_WR_BYTE,  0,    8'h00, 0, 0, 0, 1'b0);
        add_row(CMD_WR_BYTE,  2047, 8'hFF, 0, 0, 0, 1'b0);
        add_row(CMD_COMMIT,   0,    8'h00, 0, 0, 0, 1'b0);     // commit in mid-run
        add_row(CMD_WR_BYTE,  0,    8'hA5, 0, 0, 0, 1'b0);
        add_row(CMD_WR_START, 3,    8'h00, 0, 0, 0, 1'b0);     // new run replaces the old
        add_row(CMD_WR_BYTE,  0,    8'h5A, 0, 0, 0, 1'b0);
        add_row(CMD_WR_BYTE,  0,    8'h3C, 0, 0, 0, 1'b0);
        add_row(CMD_WR_BYTE,  0,    8'hC3, 0, 0, 0, 1'b0);
        add_row(CMD_WR_BYTE,  0,    8'h11, 1, 2, 1018, 1'b1);  // run used up
        add_row(CMD_PEEK,     2047, 8'h00, 0, 0, 0, 1'b0);
        add_row(CMD_READ,     1,    8'h00, 0, 0, 0, 1'b0);
        add_row(CMD_COMMIT,   0,    8'h00, 0, 0, 0, 1'b0);
        add_row(CMD_READ,     0,    8'h00, 0, 0, 0, 1'b0);
        add_row(CMD_READ,     64,   8'h00, 0, 0, 0, 1'b0);
        add_row(CMD_SPARE_6,  2047, 8'hFF, 1, 0, 1024, 1'b0);
        add_row(CMD_SPARE_7,  0,    8'h00, 1, 0, 1024, 1'b0);
        add_row(CMD_STATUS,   2047, 8'hFF, 1, 0, 1024, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            send_item(script[n].cmd, script[n].count, script[n].data);
            if (script[n].pinned)
                pending_beats[pending_beats.size() - 1] = '{8'h00, 1'b0, 1'b1, 7'd0,
                    script[n].readable, 11'(RING_DEPTH) - 11'(script[n].readable),
                    script[n].wspace, script[n].err};
        end

        // Random phases across ring sizes, extremes and out-of-range values included
        random_phase(40);
        drain_results();
        random_phase(30);
        set_ring_size(11'd2);
        random_phase(50);
        set_ring_size(11'd0);
        random_phase(30);
        set_ring_size(11'd1);
        random_phase(30);
        idle_on = 1'b0;
        set_ring_size(11'd5);
        random_phase(50);
        idle_on = 1'b1;
        set_ring_size(11'd2047);
        random_phase(40);
        set_ring_size(11'($urandom_range(3, 64)));
        random_phase(50);
        set_ring_size(11'd1025);
        random_phase(20);
        set_ring_size(11'd1024);
        random_phase(20);
        set_ring_size(11'($urandom_range(65, 1023)));
        random_phase(40);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/brb_pkg.sv
src/brb_ram.sv
src/byte_ring_buffer_with_commit_top.sv
tb/byte_ring_buffer_with_commit_top_test.sv
